### rtl/csmr_pkg.sv
package csmr_pkg;

    localparam int unsigned MAX_ITER  = 64;
    localparam int unsigned FRAC_BITS = 16;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned COEF_W = FRAC_BITS + 1;
    localparam int unsigned PROD_W = DATA_W + COEF_W;
    localparam int unsigned PASS_W = $clog2(MAX_ITER + 1);

    // round(0.10 * 2^F) and round(0.17 * 2^F)
    localparam logic [COEF_W-1:0] COEF_TENTH =
        COEF_W'(((64'd1 << FRAC_BITS) * 64'd10 + 64'd50) / 64'd100);
    localparam logic [COEF_W-1:0] COEF_SHARE =
        COEF_W'(((64'd1 << FRAC_BITS) * 64'd17 + 64'd50) / 64'd100);

    localparam logic [DATA_W-1:0] MIN_STORE_RST = 32'd328;

    typedef struct packed {
        logic [31:0] snow_in;
        logic [31:0] storage_in;
        logic [31:0] released_in;
        logic [31:0] drip_in;
    } in_item_t;

    typedef struct packed {
        logic [31:0] snow_out;
        logic [31:0] storage_out;
        logic [31:0] released_out;
        logic [31:0] drip_out;
        logic        iter_cap_hit;
    } out_item_t;

    typedef enum logic {
        COEF_SEL_TENTH,
        COEF_SEL_SHARE
    } coef_sel_t;

    typedef struct packed {
        logic      en;
        coef_sel_t sel;
    } mul_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_TENTH,
        ST_MUL_SHARE,
        ST_TEST,
        ST_REL,
        ST_DONE
    } seq_state_t;

    function automatic logic [DATA_W-1:0] sat_add(
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b
    );
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] umin(
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

endpackage

### rtl/csmr_mul.sv
module csmr_mul (
    input  logic                         clk,
    input  csmr_pkg::mul_ctrl_t          ctrl,
    input  logic [csmr_pkg::DATA_W-1:0]  a,
    output logic [csmr_pkg::DATA_W-1:0]  scaled
);
    import csmr_pkg::*;

    logic [COEF_W-1:0] coef;
    logic [PROD_W-1:0] prod_reg;

    always_comb
    begin
        case (ctrl.sel)
            COEF_SEL_TENTH: coef = COEF_TENTH;
            COEF_SEL_SHARE: coef = COEF_SHARE;
            default:        coef = COEF_TENTH;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            prod_reg <= PROD_W'(a) * PROD_W'(coef);
        end
    end

    // truncating shift back to Q format; coef < 2^F so it fits
    assign scaled = prod_reg[FRAC_BITS +: DATA_W];

endmodule

### rtl/csmr_core.sv
module csmr_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  csmr_pkg::in_item_t           item,
    input  logic [csmr_pkg::DATA_W-1:0]  min_store,
    output logic                         idle,
    output logic                         res_valid,
    input  logic                         res_ready,
    output csmr_pkg::out_item_t          res
);
    import csmr_pkg::*;

    seq_state_t        state_reg,   state_next;
    logic [DATA_W-1:0] snow_reg,    snow_next;
    logic [DATA_W-1:0] stor_reg,    stor_next;
    logic [DATA_W-1:0] rel_reg,     rel_next;
    logic [DATA_W-1:0] drip_reg,    drip_next;
    logic [DATA_W-1:0] tenth_reg,   tenth_next;
    logic [DATA_W-1:0] share_reg,   share_next;
    logic [PASS_W-1:0] passes_reg,  passes_next;
    logic              capped_reg,  capped_next;

    mul_ctrl_t         mul_ctrl;
    logic [DATA_W-1:0] scaled;
    logic [DATA_W-1:0] drop;
    logic [DATA_W-1:0] rel_amt;

    csmr_mul u_mul (
        .clk    (clk),
        .ctrl   (mul_ctrl),
        .a      (snow_reg),
        .scaled (scaled)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snow_reg   <= snow_next;
        stor_reg   <= stor_next;
        rel_reg    <= rel_next;
        drip_reg   <= drip_next;
        tenth_reg  <= tenth_next;
        share_reg  <= share_next;
        passes_reg <= passes_next;
        capped_reg <= capped_next;
    end

    assign drop    = umin(stor_reg, snow_reg);
    assign rel_amt = (snow_reg < min_store) ? '0
                   : umin(snow_reg - min_store, share_reg);

    always_comb
    begin
        state_next  = state_reg;
        snow_next   = snow_reg;
        stor_next   = stor_reg;
        rel_next    = rel_reg;
        drip_next   = drip_reg;
        tenth_next  = tenth_reg;
        share_next  = share_reg;
        passes_next = passes_reg;
        capped_next = capped_reg;
        mul_ctrl.en  = 1'b0;
        mul_ctrl.sel = COEF_SEL_TENTH;
        res_valid   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    snow_next   = item.snow_in;
                    stor_next   = item.storage_in;
                    rel_next    = item.released_in;
                    drip_next   = item.drip_in;
                    passes_next = '0;
                    capped_next = 1'b0;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (snow_reg > min_store)
                begin
                    state_next = ST_MUL_TENTH;
                end
                else
                begin
                    // at or below minimum: final drip, storage emptied
                    drip_next  = sat_add(drip_reg, drop);
                    snow_next  = snow_reg - drop;
                    stor_next  = '0;
                    state_next = ST_DONE;
                end
            end
            ST_MUL_TENTH:
            begin
                mul_ctrl.en  = 1'b1;
                mul_ctrl.sel = COEF_SEL_TENTH;
                state_next   = ST_MUL_SHARE;
            end
            ST_MUL_SHARE:
            begin
                tenth_next   = scaled;
                mul_ctrl.en  = 1'b1;
                mul_ctrl.sel = COEF_SEL_SHARE;
                state_next   = ST_TEST;
            end
            ST_TEST:
            begin
                share_next = scaled;
                if (stor_reg >= tenth_reg)
                begin
                    if (passes_reg >= PASS_W'(MAX_ITER))
                    begin
                        capped_next = 1'b1;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        passes_next = passes_reg + PASS_W'(1);
                        drip_next   = sat_add(drip_reg, tenth_reg);
                        snow_next   = snow_reg - tenth_reg;
                        stor_next   = stor_reg - tenth_reg;
                        state_next  = ST_REL;
                    end
                end
                else
                begin
                    // short storage: drip what is there, keep storage
                    drip_next  = sat_add(drip_reg, drop);
                    snow_next  = snow_reg - drop;
                    state_next = ST_DONE;
                end
            end
            ST_REL:
            begin
                rel_next   = sat_add(rel_reg, rel_amt);
                snow_next  = snow_reg - rel_amt;
                state_next = ST_CHECK;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle             = (state_reg == ST_IDLE);
    assign res.snow_out     = snow_reg;
    assign res.storage_out  = stor_reg;
    assign res.released_out = rel_reg;
    assign res.drip_out     = drip_reg;
    assign res.iter_cap_hit = capped_reg;

endmodule

### rtl/canopy_snow_mass_release_top.sv
// Each release pass steps through check, tenth and share multiply, test and
//   release; a run holds at most 64 passes, then ends in done and the output load.
// One item at a time: the next transfer is taken once the
//   sequencer is back in idle.
// The single shared scaling multiplier, used twice per pass, sets the pace.
// Reset (rst_n, async, active low): control idle, min_store back to 328.
module canopy_snow_mass_release_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  csmr_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output csmr_pkg::out_item_t   out_data,
    input  logic                  cfg_we,
    input  logic [31:0]           cfg_wdata
);
    import csmr_pkg::*;

    logic [DATA_W-1:0] min_store_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic              core_idle;
    logic              res_valid;
    logic              res_ready;
    out_item_t         res;

    // Config register; the user must write it only while the block is idle; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_store_reg <= MIN_STORE_RST;
        end
        else if (cfg_we)
        begin
            min_store_reg <= cfg_wdata;
        end
    end

    // Sequencer takes a new item only from idle.
    assign in_ready = core_idle;

    csmr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && in_ready),
        .item      (in_data),
        .min_store (min_store_reg),
        .idle      (core_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: frees the core once the result is parked here.
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

// Canopy snow mass release: standalone testbench.
//
// A directed table walks the boundary cases first. Rows whose result is
// obvious carry their result by hand. The rest are checked against the
// in-bench release predictor, as is the random part that follows. The
// random part runs in phases, one min_store setting per phase.
module tb;

    import csmr_pkg::*;

    localparam int unsigned FRAC = csmr_pkg::FRAC_BITS;
    localparam int unsigned PASS_CAP = csmr_pkg::MAX_ITER;
    // 0.10 and 0.17 rounded to FRAC fraction bits
    localparam longint unsigned TENTH_K = ((64'd1 << FRAC) * 64'd10 + 64'd50) / 64'd100;
    localparam longint unsigned SHARE_K = ((64'd1 << FRAC) * 64'd17 + 64'd50) / 64'd100;

    localparam int unsigned DIR_ROWS = 20;
    localparam int unsigned PHASES = 7;
    localparam int unsigned PHASE_ITEMS = 100;
    // Allow a drain tail beyond the longest, capped item.
    localparam int unsigned DRAIN_TAIL = 400;
    // Hang guard sized for ~720 items at their slowest, several times over.
    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    typedef enum logic [1:0] {
        RX_OPEN,      // always ready
        RX_COIN,      // ready on a coin toss
        RX_WINDOW,    // ready in a periodic window
        RX_TRICKLE    // ready when the tick is a multiple of seventeen
    } rx_mode_t;

    typedef struct {
        in_item_t    stim;
        logic [31:0] floor_mm;   // min_store for this row
        bit          typed;      // result entered by hand
        out_item_t   want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    // Predictor's copy of the register, updated at each write.
    logic [31:0] cur_min;
    out_item_t   canopy_due_q[$];
    int unsigned mismatch_cnt;
    int unsigned burst_left;

    rx_mode_t    rx_mode;
    logic [5:0]  rx_tick;

    dir_row_t    dir_tab[DIR_ROWS];

    canopy_snow_mass_release_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [31:0] sat32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Runs the release loop for one item against the given minimum store.
    function automatic out_item_t settle_canopy(in_item_t it, logic [31:0] floor_mm);
        logic [31:0] snow;
        logic [31:0] stor;
        logic [31:0] rel_tot;
        logic [31:0] drip_tot;
        logic [31:0] tenth;
        logic [31:0] share;
        logic [31:0] rel;
        logic [31:0] d;
        int unsigned passes;
        bit          done;
        bit          capped;
        out_item_t   r;
        snow     = it.snow_in;
        stor     = it.storage_in;
        rel_tot  = it.released_in;
        drip_tot = it.drip_in;
        passes   = 0;
        done     = 1'b0;
        capped   = 1'b0;
        while (!done)
        begin
            if (snow > floor_mm)
            begin
                tenth = 32'((64'(snow) * TENTH_K) >> FRAC);
                share = 32'((64'(snow) * SHARE_K) >> FRAC);
                if (stor >= tenth)
                begin
                    if (passes >= PASS_CAP)
                    begin
                        // another pass still due: stop as is, no final drip
                        capped = 1'b1;
                        done   = 1'b1;
                    end
                    else
                    begin
                        passes++;
                        drip_tot = sat32(drip_tot, tenth);
                        snow     = snow - tenth;
                        stor     = stor - tenth;
                        if (snow < floor_mm)
                            rel = '0;
                        else
                            rel = (snow - floor_mm < share) ? snow - floor_mm : share;
                        rel_tot = sat32(rel_tot, rel);
                        snow    = snow - rel;
                    end
                end
                else
                begin
                    // storage short of a tenth: final drip, storage kept
                    d        = (stor < snow) ? stor : snow;
                    drip_tot = sat32(drip_tot, d);
                    snow     = snow - d;
                    done     = 1'b1;
                end
            end
            else
            begin
                // at or below the minimum: final drip and storage cleared
                d        = (stor < snow) ? stor : snow;
                drip_tot = sat32(drip_tot, d);
                snow     = snow - d;
                stor     = '0;
                done     = 1'b1;
            end
        end
        r.snow_out     = snow;
        r.storage_out  = stor;
        r.released_out = rel_tot;
        r.drip_out     = drip_tot;
        r.iter_cap_hit = capped;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic in_item_t mk_in(logic [31:0] s, logic [31:0] st,
                                       logic [31:0] rl, logic [31:0] dr);
        in_item_t it;
        it.snow_in     = s;
        it.storage_in  = st;
        it.released_in = rl;
        it.drip_in     = dr;
        return it;
    endfunction

    function automatic out_item_t mk_out(logic [31:0] s, logic [31:0] st,
                                         logic [31:0] rl, logic [31:0] dr, logic cap);
        out_item_t r;
        r.snow_out     = s;
        r.storage_out  = st;
        r.released_out = rl;
        r.drip_out     = dr;
        r.iter_cap_hit = cap;
        return r;
    endfunction

    // Running totals: mostly random, sometimes zero or just under saturation.
    function automatic logic [31:0] rand_total();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return ~32'($urandom_range(0, 1 << 16));
            default: return $urandom;
        endcase
    endfunction

    // Snow spread over the whole range, with weight near the minimum and on
    // small loads; storage spread around the tenth and the amounts a full
    // release run consumes.
    function automatic in_item_t rand_item(logic [31:0] floor_mm);
        logic [31:0] s;
        logic [31:0] st;
        case ($urandom_range(0, 9))
            0:       s = '0;
            1:       s = 32'hFFFF_FFFF;
            2:       s = floor_mm + $urandom_range(0, 3) - 1;
            3, 4:    s = $urandom;
            5, 6:    s = $urandom_range(0, 1 << 24);
            7:       s = $urandom >> $urandom_range(0, 31);
            default: s = floor_mm + $urandom_range(0, 1 << 20);
        endcase
        case ($urandom_range(0, 7))
            0:       st = '0;
            1:       st = 32'hFFFF_FFFF;
            2:       st = 32'((64'(s) * TENTH_K) >> FRAC) + $urandom_range(0, 4) - 2;
            3:       st = $urandom;
            4, 5:    st = s >> $urandom_range(0, 4);
            default: st = $urandom >> $urandom_range(0, 31);
        endcase
        return mk_in(s, st, rand_total(), rand_total());
    endfunction

    // Present one item, hold it until the transfer, then log what it should give.
    task automatic send_item(in_item_t it, bit typed, out_item_t want);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        canopy_due_q.push_back(typed ? want : settle_canopy(it, cur_min));
    endtask

    // Sender pacing: bursts of random length, gaps of random length between
    // them, and now and then a burst with no gap at all.
    task automatic pace();
        int unsigned gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 25)
                                                  : $urandom_range(1, 4);
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // Register write only with the block idle: sender quiet, every result back.
    task automatic set_min_store(logic [31:0] v);
        @(negedge clk);
        in_valid <= 1'b0;
        while (canopy_due_q.size() != 0)
            @(negedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_min = v;
    endtask

    task automatic note_mismatch(string what, out_item_t want, out_item_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%s: want snow %h stor %h rel %h drip %h cap %b | got snow %h stor %h rel %h drip %h cap %b",
                     what, want.snow_out, want.storage_out, want.released_out,
                     want.drip_out, want.iter_cap_hit, got.snow_out, got.storage_out,
                     got.released_out, got.drip_out, got.iter_cap_hit);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Receiver stall pattern: a new mode each time the 6-bit tick wraps to zero.
    always @(negedge clk)
    begin
        if (rx_tick == 0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_tick <= rx_tick + 6'd1;
        case (rx_mode)
            RX_OPEN:    out_ready <= 1'b1;
            RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
            RX_WINDOW:  out_ready <= (rx_tick % 13) >= 9;
            default:    out_ready <= (rx_tick % 17) == 0;
        endcase
    end

    // Every result transfer is compared with the oldest expected one.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (canopy_due_q.size() == 0)
                note_mismatch("unexpected result", '0, out_data);
            else
            begin
                want = canopy_due_q.pop_front();
                if (out_data.snow_out     !== want.snow_out     ||
                    out_data.storage_out  !== want.storage_out  ||
                    out_data.released_out !== want.released_out ||
                    out_data.drip_out     !== want.drip_out     ||
                    out_data.iter_cap_hit !== want.iter_cap_hit)
                    note_mismatch("mismatch", want, out_data);
            end
        end
    end

    // Hard stop if the run hangs.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        logic [31:0] ms;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        rx_mode      = RX_OPEN;
        rx_tick      = '0;
        cur_min      = 32'd328;   // value after reset
        mismatch_cnt = 0;
        burst_left   = 0;

        // Boundary table. Rows at 328 rely on the reset value of min_store.
        // empty canopy
        dir_tab[0]  = '{mk_in(0, 0, 0, 0), 32'd328, 1'b1, mk_out(0, 0, 0, 0, 1'b0)};
        // snow exactly at the minimum: below-minimum drip, storage cleared
        dir_tab[1]  = '{mk_in(328, 100, 5, 7), 32'd328, 1'b1,
                        mk_out(228, 0, 5, 107, 1'b0)};
        // one above the minimum, no storage: short-storage exit, nothing moves
        dir_tab[2]  = '{mk_in(329, 0, 9, 11), 32'd328, 1'b1,
                        mk_out(329, 0, 9, 11, 1'b0)};
        // drip limited by snow, drip total saturates
        dir_tab[3]  = '{mk_in(100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                        32'd328, 1'b1, mk_out(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0)};
        dir_tab[4]  = '{mk_in(32'hFFFF_FFFF, 0, 32'h1234, 32'h5678), 32'd328, 1'b1,
                        mk_out(32'hFFFF_FFFF, 0, 32'h1234, 32'h5678, 1'b0)};
        // full release run from the top of the range
        dir_tab[5]  = '{mk_in(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0), 32'd328, 1'b0, '0};
        // storage short of a tenth from the start
        dir_tab[6]  = '{mk_in(32'd6553600, 32'd100000, 0, 0), 32'd328, 1'b0, '0};
        // both totals saturate during the release passes
        dir_tab[7]  = '{mk_in(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hFFFF_FFF0),
                        32'd328, 1'b0, '0};
        // storage close to one tenth
        dir_tab[8]  = '{mk_in(32'd3276800, 32'd327700, 10, 20), 32'd328, 1'b0, '0};
        // the drip takes snow below the minimum: nothing released
        dir_tab[9]  = '{mk_in(1050, 500, 0, 0), 32'd1000, 1'b0, '0};
        dir_tab[10] = '{mk_in(1001, 32'hFFFF_FFFF, 0, 0), 32'd1000, 1'b0, '0};
        // zero minimum, tiny snow: tenth and share are zero, loop hits the cap
        dir_tab[11] = '{mk_in(1, 0, 3, 4), 32'd0, 1'b1, mk_out(1, 0, 3, 4, 1'b1)};
        dir_tab[12] = '{mk_in(0, 77, 3, 4), 32'd0, 1'b1, mk_out(0, 0, 3, 4, 1'b0)};
        dir_tab[13] = '{mk_in(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0), 32'd0, 1'b0, '0};
        dir_tab[14] = '{mk_in(12345, 0, 0, 0), 32'd0, 1'b0, '0};
        // maximum minimum: everything is at or below it
        dir_tab[15] = '{mk_in(32'hFFFF_FFFF, 5, 0, 32'hFFFF_FFFE), 32'hFFFF_FFFF, 1'b1,
                        mk_out(32'hFFFF_FFFA, 0, 0, 32'hFFFF_FFFF, 1'b0)};
        dir_tab[16] = '{mk_in(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 2), 32'hFFFF_FFFF, 1'b1,
                        mk_out(0, 0, 1, 32'hFFFF_FFFF, 1'b0)};
        dir_tab[17] = '{mk_in(32'h00A0_0000, 32'h0010_0000, 32'h7FFF_FFFF, 32'h8000_0000),
                        32'h0010_0000, 1'b0, '0};
        dir_tab[18] = '{mk_in(32'h0010_0001, 32'hFFFF_FFFF, 0, 0), 32'h0010_0000, 1'b0, '0};
        // back to the reset value, written this time
        dir_tab[19] = '{mk_in(32'h8000_0000, 32'h0CCC_CCCC, 0, 0), 32'd328, 1'b0, '0};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].floor_mm != cur_min)
                set_min_store(dir_tab[i].floor_mm);
            send_item(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);
            pace();
        end

        // Random phases, one minimum store setting each, extremes included.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       ms = '0;
                1:       ms = 32'hFFFF_FFFF;
                2:       ms = $urandom_range(0, 1 << 20);
                3:       ms = $urandom;
                4:       ms = 32'd328;
                5:       ms = 32'd5;
                default: ms = 32'h0001_0000;
            endcase
            if (ms != cur_min)
                set_min_store(ms);
            repeat (PHASE_ITEMS)
            begin
                send_item(rand_item(cur_min), 1'b0, '0);
                pace();
            end
        end

        // Drain, then give any stray result a chance to show up.
        @(negedge clk);
        in_valid <= 1'b0;
        while (canopy_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        if (mismatch_cnt == 0 && canopy_due_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

### canopy_snow_mass_release_top.f
rtl/csmr_pkg.sv
rtl/csmr_mul.sv
rtl/csmr_core.sv
rtl/canopy_snow_mass_release_top.sv
tb/tb.sv
